/* src/swrl_pkg.sv */
// Package for the sliding window rate limiter: payload structs, register
// indexes and sizing constants. No dependencies.
package swrl_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_ATTEMPTS  = 64;
    localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W        = $clog2(MAX_ATTEMPTS);
    localparam int CNT_W         = $clog2(MAX_ATTEMPTS + 1);
    localparam int ADDR_W        = ENTRY_W + SLOT_W;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_AUTH    = 2'd1;
    localparam logic [1:0] REG_REFRESH = 2'd2;
    localparam logic [1:0] REG_GENERAL = 2'd3;

    localparam logic [1:0] ROUTE_LOGIN   = 2'd1;
    localparam logic [1:0] ROUTE_REFRESH = 2'd2;

    typedef struct packed {
        logic [63:0] client_key;
        logic        key_present;
        logic [1:0]  route_class;
        logic [31:0] req_time;
    } req_t;

    typedef struct packed {
        logic        allowed;
        logic [6:0]  limit_value;
        logic [6:0]  remaining;
        logic [32:0] reset_time;
        logic [15:0] retry_wait;
    } resp_t;

endpackage

/* src/swrl_log_ram.sv */
// Attempt time log store: one write port, one registered read port.
// Depends on swrl_pkg.
module swrl_log_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [swrl_pkg::ADDR_W-1:0] waddr,
    input  logic [31:0]               wdata,
    input  logic [swrl_pkg::ADDR_W-1:0] raddr,
    output logic [31:0]               rdata
);
    import swrl_pkg::*;

    logic [31:0] mem [0:TABLE_ENTRIES*MAX_ATTEMPTS-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/sliding_window_rate_limiter.sv */
// Top level of the sliding window rate limiter: sequencer, entry table,
// config registers. Depends on swrl_pkg and swrl_log_ram.
//
// Usage: pulse start with a request while busy is low. busy rises the
// next cycle and stays high until the result is ready; done then strobes
// for one cycle with the result on resp, by which time busy is low again
// and the next transaction may be accepted. The receiver cannot stall.
// Busy sequence: an absent key goes straight to the output state.
// Otherwise the entry scan walks up to TABLE_ENTRIES entries, one entry a
// cycle through the compare unit, then compaction reads each stored time
// through the registered log read and keeps those still in the window,
// then the head, decide and output states finish; done follows them.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them only while idle, as the block does not enforce this.
// Reset clears the table valid bits, counts, last-seen times and the
// config registers to their defaults; the log memory needs no clearing.
module sliding_window_rate_limiter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  swrl_pkg::req_t       req,
    output logic                 done,
    output swrl_pkg::resp_t      resp,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import swrl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_COMP  = 3'd2;
    localparam logic [2:0] ST_HEAD  = 3'd3;
    localparam logic [2:0] ST_DEC   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [15:0] window_reg;
    logic [6:0]  lim_auth_reg, lim_ref_reg, lim_gen_reg;

    logic                entry_valid_reg [TABLE_ENTRIES];
    logic [1:0]          entry_route_reg [TABLE_ENTRIES];
    logic [63:0]         entry_key_reg   [TABLE_ENTRIES];
    logic [31:0]         entry_seen_reg  [TABLE_ENTRIES];
    logic [CNT_W-1:0]    entry_count_reg [TABLE_ENTRIES];

    req_t              req_reg;
    logic [6:0]        lim_reg;
    logic [ENTRY_W:0]  scan_reg;
    logic [ENTRY_W-1:0] victim_reg, sel_reg;
    logic              have_reg;
    logic [CNT_W-1:0]  cnt_reg, rd_reg, kept_reg;
    logic              rd_pend_reg;
    resp_t             resp_reg;
    logic              done_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [31:0]       wdata, rdata;

    swrl_log_ram u_log (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic [6:0]  lim_raw, lim_clamp;
    logic [ENTRY_W-1:0] sidx;
    logic        hit;
    logic [32:0] rd_plus_win, win_sum;
    logic        keep;

    always_comb
    begin
        if (req.route_class <= ROUTE_LOGIN)
        begin
            lim_raw = lim_auth_reg;
        end
        else if (req.route_class == ROUTE_REFRESH)
        begin
            lim_raw = lim_ref_reg;
        end
        else
        begin
            lim_raw = lim_gen_reg;
        end
        if (lim_raw == 7'd0)
        begin
            lim_clamp = 7'd1;
        end
        else if (lim_raw > 7'(MAX_ATTEMPTS))
        begin
            lim_clamp = 7'(MAX_ATTEMPTS);
        end
        else
        begin
            lim_clamp = lim_raw;
        end
    end

    assign sidx = scan_reg[ENTRY_W-1:0];
    assign hit  = entry_valid_reg[sidx] && entry_route_reg[sidx] == req_reg.route_class
                  && entry_key_reg[sidx] == req_reg.client_key;
    assign rd_plus_win = {1'b0, rdata} + {17'd0, window_reg};
    assign keep = rd_plus_win > {1'b0, req_reg.req_time};
    assign win_sum = rd_plus_win;

    assign raddr = {sel_reg, rd_reg[SLOT_W-1:0]};

    always_comb
    begin
        we    = 1'b0;
        waddr = {sel_reg, kept_reg[SLOT_W-1:0]};
        wdata = rdata;
        if (state_reg == ST_COMP && rd_pend_reg && keep)
        begin
            we = 1'b1;
        end
        else if (state_reg == ST_DEC && kept_reg < CNT_W'(lim_reg))
        begin
            we    = 1'b1;
            wdata = req_reg.req_time;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = req.key_present ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN:
            begin
                if (hit || scan_reg == (ENTRY_W+1)'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                // rd_reg returns to slot 0 on the last cycle so the head is read next
                if (rd_reg >= cnt_reg && (rd_pend_reg || cnt_reg == '0))
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: state_next = ST_DEC;
            ST_DEC:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            window_reg   <= 16'd60;
            lim_auth_reg <= 7'd5;
            lim_ref_reg  <= 7'd10;
            lim_gen_reg  <= 7'd60;
            done_reg     <= 1'b0;
            rd_pend_reg  <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
                entry_seen_reg[i]  <= 32'd0;
                entry_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW:  window_reg   <= cfg_data;
                    REG_AUTH:    lim_auth_reg <= cfg_data[6:0];
                    REG_REFRESH: lim_ref_reg  <= cfg_data[6:0];
                    REG_GENERAL: lim_gen_reg  <= cfg_data[6:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg  <= req;
                        lim_reg  <= lim_clamp;
                        scan_reg <= '0;
                        have_reg <= 1'b0;
                        victim_reg <= '0;
                        resp_reg <= '{allowed: 1'b0, limit_value: lim_clamp,
                                      remaining: 7'd0, reset_time: 33'd0,
                                      retry_wait: 16'd0};
                    end
                end
                ST_SCAN:
                begin
                    rd_reg   <= '0;
                    kept_reg <= '0;
                    rd_pend_reg <= 1'b0;
                    if (hit)
                    begin
                        sel_reg <= sidx;
                        cnt_reg <= entry_count_reg[sidx];
                    end
                    else
                    begin
                        logic take;
                        logic [ENTRY_W-1:0] v;
                        take = !entry_valid_reg[sidx] || !have_reg
                               || entry_seen_reg[sidx] < entry_seen_reg[victim_reg];
                        v = take ? sidx : victim_reg;
                        victim_reg <= v;
                        have_reg   <= 1'b1;
                        scan_reg   <= scan_reg + 1'b1;
                        if (scan_reg == (ENTRY_W+1)'(TABLE_ENTRIES - 1))
                        begin
                            sel_reg <= v;
                            cnt_reg <= '0;
                            entry_valid_reg[v] <= 1'b1;
                            entry_route_reg[v] <= req_reg.route_class;
                            entry_key_reg[v]   <= req_reg.client_key;
                        end
                    end
                end
                ST_COMP:
                begin
                    if (rd_pend_reg && keep)
                    begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                    rd_pend_reg <= rd_reg < cnt_reg;
                    if (rd_reg < cnt_reg)
                    begin
                        rd_reg <= rd_reg + 1'b1;
                    end
                    else
                    begin
                        rd_reg <= '0;
                    end
                end
                ST_HEAD: ;
                ST_DEC:
                begin
                    entry_seen_reg[sel_reg] <= req_reg.req_time;
                    if (kept_reg >= CNT_W'(lim_reg))
                    begin
                        entry_count_reg[sel_reg] <= kept_reg;
                        resp_reg.reset_time <= win_sum;
                        if (win_sum > {1'b0, req_reg.req_time})
                        begin
                            logic [32:0] w;
                            w = win_sum - {1'b0, req_reg.req_time};
                            resp_reg.retry_wait <= (w > 33'hFFFF) ? 16'hFFFF : w[15:0];
                        end
                        else
                        begin
                            resp_reg.retry_wait <= 16'd1;
                        end
                    end
                    else
                    begin
                        entry_count_reg[sel_reg] <= kept_reg + 1'b1;
                        resp_reg.allowed   <= 1'b1;
                        resp_reg.remaining <= lim_reg - 7'(kept_reg) - 7'd1;
                        resp_reg.reset_time <= (kept_reg == '0)
                            ? {1'b0, req_reg.req_time} + {17'd0, window_reg}
                            : win_sum;
                    end
                end
                ST_OUT:
                begin
                    done_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign busy = state_reg != ST_IDLE;
    assign done = done_reg;
    assign resp = resp_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_deny_retry: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !resp.allowed && resp.reset_time != 33'd0) |-> resp.retry_wait != 16'd0)
        else $error("denial without retry delay");
    a_allow_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (done && resp.allowed) |-> resp.remaining < resp.limit_value)
        else $error("remaining out of range");
`endif
endmodule

/* tb/sv/swrl_checker.sv */
// Checker for the sliding window rate limiter: watches the request and
// response channels and compares each response with its prediction.
// Depends on swrl_pkg.
`timescale 1ns / 1ps

module swrl_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  swrl_pkg::req_t  req,
    input  logic            done,
    input  swrl_pkg::resp_t resp,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    output int              fail_count,
    output int              pending
);
    import swrl_pkg::*;

    logic [15:0] window_len;
    logic [6:0]  lim_auth, lim_refresh, lim_general;
    logic        tbl_valid [TABLE_ENTRIES];
    logic [1:0]  tbl_route [TABLE_ENTRIES];
    logic [63:0] tbl_key [TABLE_ENTRIES];
    logic [31:0] tbl_seen [TABLE_ENTRIES];
    int          tbl_count [TABLE_ENTRIES];
    logic [31:0] hist [TABLE_ENTRIES][MAX_ATTEMPTS];
    resp_t       expected_resps [$];

    function automatic int route_cap(input logic [1:0] route);
        int l;
        if (route <= ROUTE_LOGIN)
            l = lim_auth;
        else if (route == ROUTE_REFRESH)
            l = lim_refresh;
        else
            l = lim_general;
        if (l < 1)
            l = 1;
        if (l > MAX_ATTEMPTS)
            l = MAX_ATTEMPTS;
        return l;
    endfunction

    function automatic resp_t admit(input req_t r);
        resp_t o;
        int l, e, victim, kept, cnt;
        bit have, found;
        logic [32:0] rst_at, wait_s;
        l = route_cap(r.route_class);
        o = '0;
        o.limit_value = l[6:0];
        if (!r.key_present)
            return o;
        victim = 0;
        have = 0;
        found = 0;
        e = 0;
        for (int i = 0; i < TABLE_ENTRIES && !found; i++) begin
            if (tbl_valid[i] && tbl_route[i] == r.route_class && tbl_key[i] == r.client_key)
            begin
                e = i;
                found = 1;
            end
            else if (!tbl_valid[i] || !have || tbl_seen[i] < tbl_seen[victim])
            begin
                victim = i;
                have = 1;
            end
        end
        if (!found)
        begin
            e = victim;
            tbl_valid[e] = 1;
            tbl_route[e] = r.route_class;
            tbl_key[e] = r.client_key;
            tbl_seen[e] = 0;
            tbl_count[e] = 0;
        end
        cnt = tbl_count[e];
        kept = 0;
        for (int i = 0; i < cnt; i++)
            if ({1'b0, hist[e][i]} + {17'd0, window_len} > {1'b0, r.req_time})
            begin
                hist[e][kept] = hist[e][i];
                kept++;
            end
        cnt = kept;
        tbl_seen[e] = r.req_time;
        if (cnt >= l)
        begin
            rst_at = {1'b0, hist[e][0]} + {17'd0, window_len};
            if (rst_at > {1'b0, r.req_time})
            begin
                wait_s = rst_at - {1'b0, r.req_time};
                if (wait_s > 33'hFFFF)
                    wait_s = 33'hFFFF;
            end
            else
                wait_s = 33'd1;
            o.reset_time = rst_at;
            o.retry_wait = wait_s[15:0];
        end
        else
        begin
            hist[e][cnt] = r.req_time;
            cnt++;
            o.allowed = 1;
            o.remaining = 7'(l - cnt);
            o.reset_time = {1'b0, hist[e][0]} + {17'd0, window_len};
        end
        tbl_count[e] = cnt;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        resp_t want;
        if (!rst_n)
        begin
            window_len <= 16'd60;
            lim_auth <= 7'd5;
            lim_refresh <= 7'd10;
            lim_general <= 7'd60;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                tbl_valid[i] = 0;
                tbl_seen[i] = 0;
                tbl_count[i] = 0;
            end
            expected_resps.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    REG_WINDOW:  window_len <= cfg_data;
                    REG_AUTH:    lim_auth <= cfg_data[6:0];
                    REG_REFRESH: lim_refresh <= cfg_data[6:0];
                    REG_GENERAL: lim_general <= cfg_data[6:0];
                endcase
            if (done)
            begin
                if (expected_resps.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected transaction: %p", resp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_resps.pop_front();
                    if (want !== resp)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, resp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_resps.push_back(admit(req));
            pending <= expected_resps.size();
        end
    end
endmodule

/* tb/sv/testbench.sv */
// Top of the rate limiter testbench: clock, reset, request and register
// stimulus, verdict. Depends on swrl_pkg, swrl_checker and the block.
`timescale 1ns / 1ps

module testbench;
    import swrl_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    resp_t       resp;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    longint      cycles;
    logic [63:0] key_pool [8];
    logic [31:0] clock_s;

    sliding_window_rate_limiter DUT (.*);

    swrl_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send(input logic [63:0] k, input logic p, input logic [1:0] rt,
                        input logic [31:0] t);
        while (busy)
            @(posedge clk);
        start <= 1;
        req <= '{client_key: k, key_present: p, route_class: rt, req_time: t};
        @(posedge clk);
        start <= 0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic random_phase(input int n);
        int burst;
        logic [31:0] t;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                repeat ($urandom_range(0, 6)) @(posedge clk);
            end
            burst--;
            clock_s = clock_s + $urandom_range(0, 4);
            t = ($urandom_range(0, 30) == 0) ? $urandom() : clock_s;
            send(($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()}
                     : key_pool[$urandom_range(0, 7)],
                 $urandom_range(0, 15) != 0, 2'($urandom_range(0, 3)), t);
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        req = '0;
        cfg_we = 0;
        cfg_index = REG_WINDOW;
        cfg_data = '0;
        foreach (key_pool[i])
            key_pool[i] = {$urandom(), $urandom()};
        clock_s = 1000;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, all routes, absent key, exhaustion, time backwards
        send(64'h0, 1'b0, 2'd0, 32'd0);
        send('1, 1'b1, 2'd3, 32'hFFFF_FFFF);
        for (int i = 0; i < 7; i++)
            send(64'h5, 1'b1, 2'd1, 32'd100);
        send(64'h5, 1'b1, 2'd1, 32'd50);
        send(64'h5, 1'b1, 2'd1, 32'd160);
        send(64'h6, 1'b1, 2'd2, 32'd7);
        send(64'h6, 1'b1, 2'd0, 32'd7);
        send(64'h6, 1'b0, 2'd3, 32'd7);
        write_reg(REG_WINDOW, 16'd0);
        write_reg(REG_AUTH, 16'd0);
        send(64'h7, 1'b1, 2'd0, 32'd10);
        send(64'h7, 1'b1, 2'd0, 32'd10);
        send(64'h7, 1'b1, 2'd0, 32'd9);
        write_reg(REG_WINDOW, 16'hFFFF);
        write_reg(REG_AUTH, 16'h7F);
        write_reg(REG_REFRESH, 16'd64);
        write_reg(REG_GENERAL, 16'd1);
        send(64'h8, 1'b1, 2'd3, 32'd5);
        send(64'h8, 1'b1, 2'd3, 32'd0);
        send(64'h8, 1'b1, 2'd3, 32'hFFFF_FFFF);
        random_phase(300);
        write_reg(REG_WINDOW, 16'd20);
        write_reg(REG_AUTH, 16'd3);
        write_reg(REG_REFRESH, 16'd0);
        write_reg(REG_GENERAL, 16'hFF80 | 16'd8);
        random_phase(350);
        write_reg(REG_WINDOW, 16'd1);
        write_reg(REG_AUTH, 16'd64);
        write_reg(REG_REFRESH, 16'd2);
        write_reg(REG_GENERAL, 16'd64);
        random_phase(350);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
